>>> hw/rtl/i2da_pkg.sv
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

	// Width of the number that is converted
	localparam int VALUE_BITS = 64;

	// Decimal digits needed for 2^VALUE_BITS - 1 (1233/4096 ~ log10(2))
	localparam int NDIG = ((VALUE_BITS * 1233) >> 12) + 1;

	// Counter widths
	localparam int BIT_CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int DIG_CW = $clog2(NDIG + 1);

	// ASCII codes
	localparam logic [6:0] CODE_ZERO  = 7'd48;
	localparam logic [6:0] CODE_MINUS = 7'd45;

	// Operation applied to every cell of the digit chain
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_BIT,
		CELL_DIGIT
	} cell_op_t;

	// Controller state
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_TRIM,
		ST_EMIT
	} state_t;

	// Input item
	typedef struct packed {
		logic        func;
		logic [63:0] value;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic [6:0] char_code;
		logic       last;
	} out_item_t;

	// Chain control from the controller
	typedef struct packed {
		cell_op_t op;
		logic     bit_in;
	} chain_ctl_t;

endpackage

>>> hw/rtl/i2da_cell.sv
// ----------------------------------------------------------------------------
// i2da_cell
// One BCD digit of the shift-add-3 chain. Shifts in a binary bit from the
// lower neighbor, or takes the lower neighbor's whole digit.
// ----------------------------------------------------------------------------
module i2da_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  i2da_pkg::cell_op_t op,
	input  logic               carry_in,
	input  logic [3:0]         digit_in,
	output logic               carry_out,
	output logic [3:0]         digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	// Add 3 when the digit would overflow 9 after doubling
	always_comb begin
		adj = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
	end

	assign carry_out = adj[3];
	assign digit     = digit_q;

	// Digit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= 4'd0;
		end else begin
			case (op)
				i2da_pkg::CELL_CLEAR: digit_q <= 4'd0;
				i2da_pkg::CELL_BIT:   digit_q <= {adj[2:0], carry_in};
				i2da_pkg::CELL_DIGIT: digit_q <= digit_in;
				default:              digit_q <= digit_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/i2da_chain.sv
// ----------------------------------------------------------------------------
// i2da_chain
// Row of BCD cells, least significant digit at index 0. Binary bits and
// digits both move toward the most significant end.
// ----------------------------------------------------------------------------
module i2da_chain (
	input  logic                 clk,
	input  logic                 arst_n,
	input  i2da_pkg::chain_ctl_t ctl,
	output logic [3:0]           top_digit
);

	logic [i2da_pkg::NDIG:0] carry;
	logic [3:0]              digits [i2da_pkg::NDIG];

	assign carry[0] = ctl.bit_in;

	// Cell row
	for (genvar i = 0; i < i2da_pkg::NDIG; i++) begin : g_cell
		logic [3:0] dig_in;
		if (i == 0) begin : g_first
			assign dig_in = 4'd0;
		end else begin : g_rest
			assign dig_in = digits[i-1];
		end
		i2da_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (ctl.op),
			.carry_in  (carry[i]),
			.digit_in  (dig_in),
			.carry_out (carry[i+1]),
			.digit     (digits[i])
		);
	end

	assign top_digit = digits[i2da_pkg::NDIG-1];

endmodule

>>> hw/rtl/integer_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_top
// Operation: the magnitude is shifted MSB first into the digit chain, leading zero
// digits are then trimmed, and the text leaves one character per cycle through an
// output register, a minus sign first for a negative signed number. A new number is
// taken only while idle, after the last character of the previous one is emitted.
// Reset clears the controller, the digit chain and the result strobe; no stalls.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  i2da_pkg::in_item_t  item,
	output logic                strobe,
	output i2da_pkg::out_item_t result
);

	localparam int VB = i2da_pkg::VALUE_BITS;

	i2da_pkg::state_t     state_q, state_nxt;
	i2da_pkg::chain_ctl_t ctl;
	logic [VB-1:0]        mag_q;
	logic [VB-1:0]        raw;
	logic [i2da_pkg::BIT_CW-1:0] bit_cnt_q;
	logic [i2da_pkg::DIG_CW-1:0] ndig_q;
	logic                 neg_q;
	logic [3:0]           top_digit;
	logic                 take;
	logic                 emit;
	i2da_pkg::out_item_t  emit_item;
	logic                 strobe_q;
	i2da_pkg::out_item_t  result_q;

	assign raw  = item.value[VB-1:0];
	assign take = start && (state_q == i2da_pkg::ST_IDLE);
	assign busy = (state_q != i2da_pkg::ST_IDLE);

	// Digit chain
	i2da_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.top_digit (top_digit)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			i2da_pkg::ST_IDLE: if (start) state_nxt = i2da_pkg::ST_CONV;
			i2da_pkg::ST_CONV: if (bit_cnt_q == '0) state_nxt = i2da_pkg::ST_TRIM;
			i2da_pkg::ST_TRIM: begin
				if (!(top_digit == 4'd0 && ndig_q > 1)) state_nxt = i2da_pkg::ST_EMIT;
			end
			i2da_pkg::ST_EMIT: begin
				if (!neg_q && ndig_q == 1) state_nxt = i2da_pkg::ST_IDLE;
			end
			default: state_nxt = i2da_pkg::ST_IDLE;
		endcase
	end

	// Chain control and character output
	always_comb begin
		ctl.op    = i2da_pkg::CELL_HOLD;
		ctl.bit_in = mag_q[VB-1];
		emit      = 1'b0;
		emit_item.char_code = i2da_pkg::CODE_ZERO + {3'b000, top_digit};
		emit_item.last      = (ndig_q == 1);
		case (state_q)
			i2da_pkg::ST_IDLE: ctl.op = i2da_pkg::CELL_CLEAR;
			i2da_pkg::ST_CONV: ctl.op = i2da_pkg::CELL_BIT;
			i2da_pkg::ST_TRIM: begin
				if (top_digit == 4'd0 && ndig_q > 1) ctl.op = i2da_pkg::CELL_DIGIT;
			end
			i2da_pkg::ST_EMIT: begin
				emit = 1'b1;
				if (neg_q) begin
					emit_item.char_code = i2da_pkg::CODE_MINUS;
					emit_item.last      = 1'b0;
				end else begin
					ctl.op = i2da_pkg::CELL_DIGIT;
				end
			end
			default: ctl.op = i2da_pkg::CELL_HOLD;
		endcase
	end

	// Controller registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= i2da_pkg::ST_IDLE;
			bit_cnt_q <= '0;
			ndig_q    <= '0;
			neg_q     <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			strobe_q <= emit;
			if (take) begin
				bit_cnt_q <= i2da_pkg::BIT_CW'(VB - 1);
				ndig_q    <= i2da_pkg::DIG_CW'(i2da_pkg::NDIG);
				neg_q     <= item.func && raw[VB-1];
			end else begin
				if (state_q == i2da_pkg::ST_CONV) bit_cnt_q <= bit_cnt_q - 1'b1;
				if (ctl.op == i2da_pkg::CELL_DIGIT) ndig_q <= ndig_q - 1'b1;
				if (emit && neg_q) neg_q <= 1'b0;
			end
		end
	end

	// Magnitude shift register, MSB first into the chain
	always_ff @(posedge clk) begin
		if (take) begin
			mag_q <= (item.func && raw[VB-1]) ? (~raw + 1'b1) : raw;
		end else if (state_q == i2da_pkg::ST_CONV) begin
			mag_q <= {mag_q[VB-2:0], 1'b0};
		end
	end

	// Result payload register
	always_ff @(posedge clk) begin
		if (emit) result_q <= emit_item;
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for integer_to_decimal_ascii_top. Numbers are sent as
// commands in random bursts; every character that comes back is compared with
// the decimal text worked out here, directed extremes first, then random
// values of mixed length and signedness.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

	localparam logic FUNC_UNSIGNED = 1'b0;
	localparam logic FUNC_SIGNED   = 1'b1;
	localparam int   RANDOM_ITEMS  = 250;
	localparam int   CYCLE_LIMIT   = 400000;
	localparam int   DRAIN_CYCLES  = i2da_pkg::VALUE_BITS + i2da_pkg::NDIG + 40;

	// One row of directed stimulus; an empty text means use the predictor
	typedef struct {
		logic        func;
		logic [63:0] value;
		string       text;
	} vec_t;

	logic                clk    = 1'b0;
	logic                arst_n = 1'b0;
	logic                start  = 1'b0;
	i2da_pkg::in_item_t  item   = '0;
	logic                busy;
	logic                strobe;
	i2da_pkg::out_item_t result;

	i2da_pkg::out_item_t pending_chars[$];
	vec_t                directed[$];
	int                  errors     = 0;
	int                  cycles     = 0;
	int                  burst_left = 0;

	integer_to_decimal_ascii_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	always #1 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic report(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// Decimal text of one number, queued as expected characters
	function automatic void predict_text(input i2da_pkg::in_item_t x);
		logic [63:0] mask;
		logic [63:0] sign_bit;
		logic [63:0] mag;
		logic        neg;
		logic [3:0]  digs[$];
		mask     = {64{1'b1}} >> (64 - i2da_pkg::VALUE_BITS);
		sign_bit = 64'd1 << (i2da_pkg::VALUE_BITS - 1);
		mag      = x.value & mask;
		neg      = (x.func == FUNC_SIGNED) && ((mag & sign_bit) != 0);
		if (neg)
			mag = (~mag + 64'd1) & mask;
		if (mag == 0) begin
			pending_chars.push_back(i2da_pkg::out_item_t'{char_code: i2da_pkg::CODE_ZERO,
				last: 1'b1});
			return;
		end
		while (mag != 0) begin
			digs.push_front(4'(mag % 64'd10));
			mag = mag / 64'd10;
		end
		if (neg)
			pending_chars.push_back(i2da_pkg::out_item_t'{char_code: i2da_pkg::CODE_MINUS,
				last: 1'b0});
		foreach (digs[i])
			pending_chars.push_back(i2da_pkg::out_item_t'{
				char_code: i2da_pkg::CODE_ZERO + 7'(digs[i]),
				last: (i == digs.size() - 1)});
	endfunction

	// Text typed in by hand, queued as expected characters
	function automatic void expect_literal(input string s);
		for (int i = 0; i < s.len(); i++)
			pending_chars.push_back(i2da_pkg::out_item_t'{char_code: 7'(s[i]),
				last: (i == s.len() - 1)});
	endfunction

	// Hold the command until the transfer happens, then queue what it must give
	task automatic issue(input logic func, input logic [63:0] value, input string text);
		i2da_pkg::in_item_t x;
		x.func  = func;
		x.value = value;
		item  <= x;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		if (text.len() != 0)
			expect_literal(text);
		else
			predict_text(x);
	endtask

	// Bursts of back-to-back commands separated by random gaps
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 120);
		start <= 1'b0;
		item  <= {1'($urandom), $urandom, $urandom};
		repeat (gap) @(posedge clk);
		burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 6);
	endtask

	function automatic logic [63:0] random_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: ;
			1: v = v >> $urandom_range(0, 63);
			2: v = 64'($urandom_range(0, 1000));
			default: v = ~(64'($urandom_range(0, 1000)));
		endcase
		return v;
	endfunction

	// Result checker: every strobe must match the oldest expected character
	always @(posedge clk) begin
		i2da_pkg::out_item_t want;
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				report($sformatf("unexpected character %0d", result.char_code));
			end else begin
				want = pending_chars.pop_front();
				if (result.char_code !== want.char_code)
					report($sformatf("char_code %0d, wanted %0d",
						result.char_code, want.char_code));
				if (result.last !== want.last)
					report($sformatf("last %0b, wanted %0b", result.last, want.last));
			end
		end
	end

	initial begin
		logic [63:0] v;

		directed.push_back('{FUNC_UNSIGNED, 64'd0, "0"});
		directed.push_back('{FUNC_SIGNED, 64'd0, "0"});
		directed.push_back('{FUNC_UNSIGNED, 64'd1, "1"});
		directed.push_back('{FUNC_UNSIGNED, 64'd9, "9"});
		directed.push_back('{FUNC_UNSIGNED, 64'd10, "10"});
		directed.push_back('{FUNC_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, "18446744073709551615"});
		directed.push_back('{FUNC_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF, "-1"});
		directed.push_back('{FUNC_SIGNED, 64'h8000_0000_0000_0000, "-9223372036854775808"});
		directed.push_back('{FUNC_UNSIGNED, 64'h8000_0000_0000_0000, "9223372036854775808"});
		directed.push_back('{FUNC_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, "9223372036854775807"});
		directed.push_back('{FUNC_SIGNED, 64'hFFFF_FFFF_FFFF_FFF6, "-10"});
		directed.push_back('{FUNC_UNSIGNED, 64'd10000000000000000000, "10000000000000000000"});
		directed.push_back('{FUNC_UNSIGNED, 64'd9999999999999999999, "9999999999999999999"});
		directed.push_back('{FUNC_SIGNED, 64'd1, "1"});
		directed.push_back('{FUNC_SIGNED, 64'h8000_0000_0000_0001, ""});
		directed.push_back('{FUNC_UNSIGNED, 64'hAAAA_AAAA_AAAA_AAAA, ""});
		directed.push_back('{FUNC_SIGNED, 64'h5555_5555_5555_5555, ""});
		directed.push_back('{FUNC_SIGNED, 64'hCAFE_0000_1234_5678, ""});
		directed.push_back('{FUNC_UNSIGNED, 64'd100, ""});
		directed.push_back('{FUNC_SIGNED, 64'hFFFF_FFFF_FFFF_FF9C, ""});

		// Reset
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part
		foreach (directed[i]) begin
			issue(directed[i].func, directed[i].value, directed[i].text);
			pace();
		end

		// Random part
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			v = random_value();
			issue(1'($urandom), v, "");
			pace();
		end
		start <= 1'b0;

		// Drain
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/i2da_pkg.sv
hw/rtl/i2da_cell.sv
hw/rtl/i2da_chain.sv
hw/rtl/integer_to_decimal_ascii_top.sv
sim/tb.sv
